// ----- design/fdc_pkg.sv -----
// ============================================================================
// Floppy disk controller package
// Shared transaction types, register map and command codes.
// ============================================================================
`default_nettype none

package fdc_pkg;

    // Register map of the host bus
    localparam logic [1:0] REG_CMD    = 2'd0;
    localparam logic [1:0] REG_TRACK  = 2'd1;
    localparam logic [1:0] REG_SECTOR = 2'd2;
    localparam logic [1:0] REG_DATA   = 2'd3;

    // Bus access kind
    localparam logic REQ_READ  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    // Configuration register indexes
    localparam logic CFG_SIDE_SELECT = 1'b0;

    // Command codes, upper nibble of the command register
    localparam logic [3:0] CMD_RESTORE    = 4'h0;
    localparam logic [3:0] CMD_SEEK       = 4'h1;
    localparam logic [3:0] CMD_STEP_IN    = 4'h4;
    localparam logic [3:0] CMD_STEP_IN_U  = 4'h5;
    localparam logic [3:0] CMD_STEP_OUT   = 4'h6;
    localparam logic [3:0] CMD_STEP_OUT_U = 4'h7;
    localparam logic [3:0] CMD_READ_SEC   = 4'h8;
    localparam logic [3:0] CMD_READ_SEC_M = 4'h9;
    localparam logic [3:0] CMD_FORCE_INT  = 4'hD;

    // Status register bits
    localparam int unsigned ST_BUSY   = 0;
    localparam int unsigned ST_DRQ    = 1;
    localparam int unsigned ST_TRACK0 = 2;

    localparam logic [7:0] ST_BUSY_ONLY = 8'h01;
    localparam logic [7:0] INDEX_MASK   = 8'h0E;
    localparam logic [7:0] WAIT_SPENT   = 8'hFF;

    typedef struct packed {
        logic       req_type;
        logic [1:0] reg_addr;
        logic [7:0] write_data;
        logic [7:0] disk_byte;
    } t_req;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        drq_line;
        logic        intrq_line;
        logic        disk_fetch;
        logic [31:0] disk_offset;
    } t_rsp;

endpackage

`default_nettype wire

// ----- design/fdc_req_if.sv -----
// ============================================================================
// Floppy disk controller request channel
// Valid/ready channel carrying one host bus access.
// ============================================================================
`default_nettype none

interface fdc_req_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [1:0] reg_addr;
    logic [7:0] write_data;
    logic [7:0] disk_byte;

    modport source (output valid, output req_type, output reg_addr,
                    output write_data, output disk_byte, input ready);
    modport sink   (input valid, input req_type, input reg_addr,
                    input write_data, input disk_byte, output ready);
endinterface

`default_nettype wire

// ----- design/fdc_rsp_if.sv -----
// ============================================================================
// Floppy disk controller response channel
// Valid/ready channel carrying the result of one host bus access.
// ============================================================================
`default_nettype none

interface fdc_rsp_if;
    logic        valid;
    logic        ready;
    logic [7:0]  read_data;
    logic        drq_line;
    logic        intrq_line;
    logic        disk_fetch;
    logic [31:0] disk_offset;

    modport source (output valid, output read_data, output drq_line,
                    output intrq_line, output disk_fetch, output disk_offset,
                    input ready);
    modport sink   (input valid, input read_data, input drq_line,
                    input intrq_line, input disk_fetch, input disk_offset,
                    output ready);
endinterface

`default_nettype wire

// ----- design/floppy_disk_controller_core.sv -----
// ============================================================================
// Floppy disk controller core
// Four-register floppy controller with command sequencer and sector reader.
// ============================================================================
//
//  Channel  | Dir | Handshake          | Carries
//  ---------+-----+--------------------+------------------------------------------
//  i_req    | in  | valid/ready        | req_type, reg_addr, write_data, disk_byte
//  o_rsp    | out | valid/ready        | read_data, drq/intrq lines, disk_fetch,
//           |     |                    | disk_offset
//  i_cfg_*  | in  | write enable only  | side_select (index 0), drive_select (1)
//
// One transaction per cycle sustained while o_rsp is not stalled. A transaction
// accepted from i_req waits in the input register; the result register presents its result.
// The whole sequencer pass of an access (command decode, delay, type I or read
// step, idle) settles in the one stage between those two registers.
// A stalled o_rsp holds the result register and backs up into i_req.
// Reset is synchronous and needs no clearing pass.
// Drive select only names the image the offsets refer to and is not stored.
// ============================================================================
`default_nettype none

module floppy_disk_controller_core #(
    parameter int unsigned SECTOR_BYTES     = 1024,
    parameter int unsigned SECTORS_PER_SIDE = 5,
    parameter int unsigned TOP_TRACK        = 80,
    parameter int unsigned WAIT_STEPS       = 3
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    fdc_req_if.sink         i_req,
    fdc_rsp_if.source       o_rsp,
    input  wire logic       i_cfg_we,
    input  wire logic       i_cfg_idx,
    input  wire logic [1:0] i_cfg_wdata
);

    fdc_pkg::t_req w_item;
    logic          w_item_valid;
    logic          w_fire;
    fdc_pkg::t_rsp w_rsp;

    fdc_pkg::t_rsp r_rsp;
    logic          r_out_valid;
    logic          r_side;

    // Run the sequencer when an item waits and the result slot is free
    assign w_fire = w_item_valid && (!r_out_valid || o_rsp.ready);

    // Hold the incoming transaction
    fdc_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_take  (w_fire),
        .o_item  (w_item),
        .o_valid (w_item_valid)
    );

    // Advance the sequencer and perform the register access
    fdc_seq #(
        .SECTOR_BYTES     (SECTOR_BYTES),
        .SECTORS_PER_SIDE (SECTORS_PER_SIDE),
        .TOP_TRACK        (TOP_TRACK),
        .WAIT_STEPS       (WAIT_STEPS)
    ) u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_item  (w_item),
        .i_side  (r_side),
        .o_rsp   (w_rsp)
    );

    // Configuration: side select feeds the sector offset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side <= 1'b0;
        end else if (i_cfg_we && i_cfg_idx == fdc_pkg::CFG_SIDE_SELECT) begin
            r_side <= i_cfg_wdata[0];
        end
    end

    // Result register: load on a pass, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_rsp <= w_rsp;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.read_data   = r_rsp.read_data;
    assign o_rsp.drq_line    = r_rsp.drq_line;
    assign o_rsp.intrq_line  = r_rsp.intrq_line;
    assign o_rsp.disk_fetch  = r_rsp.disk_fetch;
    assign o_rsp.disk_offset = r_rsp.disk_offset;

endmodule

`default_nettype wire

// ----- design/fdc_in_reg.sv -----
// ============================================================================
// Floppy disk controller input register
// Captures one request transaction and holds it until the sequencer takes it.
// ============================================================================
`default_nettype none

module fdc_in_reg (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    fdc_req_if.sink      i_req,
    input  wire logic    i_take,
    output fdc_pkg::t_req o_item,
    output logic         o_valid
);

    logic          r_valid;
    fdc_pkg::t_req r_item;
    logic          w_load;

    // Free when empty or when the held item leaves this cycle
    assign i_req.ready = !r_valid || i_take;
    assign w_load      = i_req.valid && i_req.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_item.req_type   <= i_req.req_type;
            r_item.reg_addr   <= i_req.reg_addr;
            r_item.write_data <= i_req.write_data;
            r_item.disk_byte  <= i_req.disk_byte;
        end
    end

    assign o_item  = r_item;
    assign o_valid = r_valid;

endmodule

`default_nettype wire

// ----- design/fdc_seq.sv -----
// ============================================================================
// Floppy disk controller sequencer
// Register file and command sequencer; one pass and one bus access per item.
// ============================================================================
`default_nettype none

module fdc_seq #(
    parameter int unsigned SECTOR_BYTES     = 1024,
    parameter int unsigned SECTORS_PER_SIDE = 5,
    parameter int unsigned TOP_TRACK        = 80,
    parameter int unsigned WAIT_STEPS       = 3
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_fire,
    input  wire fdc_pkg::t_req i_item,
    input  wire logic          i_side,
    output fdc_pkg::t_rsp      o_rsp
);

    localparam int unsigned BC_W = $clog2(SECTOR_BYTES + 1);
    localparam logic [BC_W-1:0] SECTOR_LEN  = BC_W'(SECTOR_BYTES);
    localparam logic [31:0]     K_TRACK     = 32'(2 * SECTORS_PER_SIDE * SECTOR_BYTES);
    localparam logic [31:0]     K_SIDE      = 32'(SECTORS_PER_SIDE * SECTOR_BYTES);
    localparam logic [31:0]     K_SECTOR    = 32'(SECTOR_BYTES);
    localparam logic [7:0]      TRACK_LIMIT = 8'(TOP_TRACK);
    localparam logic [7:0]      WAIT_LOAD   = 8'(WAIT_STEPS);

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_DELAY   = 3'd1,
        PH_COMMAND = 3'd2,
        PH_TYPE1   = 3'd3,
        PH_READING = 3'd4
    } t_phase;

    t_phase          r_phase,   n_phase;
    t_phase          r_paw,     n_paw;
    logic [7:0]      r_status,  n_status;
    logic [7:0]      r_data,    n_data;
    logic [7:0]      r_track,   n_track;
    logic [7:0]      r_sector,  n_sector;
    logic [7:0]      r_command, n_command;
    logic [7:0]      r_head,    n_head;
    logic            r_drq,     n_drq;
    logic            r_intrq,   n_intrq;
    logic [7:0]      r_wait,    n_wait;
    logic [7:0]      r_index,   n_index;
    logic [BC_W-1:0] r_bc,      n_bc;
    logic [31:0]     r_base,    n_base;

    logic [31:0]     w_new_base;
    logic            w_fetch;
    logic [7:0]      w_rdata;

    // Image offset of the first byte of the addressed sector (wraps for sector 0 on track 0, side 0)
    assign w_new_base = 32'(r_track) * K_TRACK
                      + (i_side ? K_SIDE : 32'd0)
                      + 32'(r_sector) * K_SECTOR
                      - K_SECTOR;

    // The pass walks the phases in the only order they can follow each other:
    // command, delay, type I or read, delay, read, idle.
    always_comb begin
        t_phase v_ph;
        logic   v_done;
        logic   v_fetch;

        v_ph    = r_phase;
        v_done  = 1'b0;
        v_fetch = 1'b0;

        n_paw     = r_paw;
        n_status  = r_status;
        n_data    = r_data;
        n_track   = r_track;
        n_sector  = r_sector;
        n_command = r_command;
        n_head    = r_head;
        n_drq     = r_drq;
        n_intrq   = r_intrq;
        n_wait    = r_wait;
        n_bc      = r_bc;
        n_base    = r_base;
        n_index   = r_index + 8'd1;
        w_rdata   = 8'd0;

        // Command decode
        if (v_ph == PH_COMMAND) begin
            if (r_command[7:4] == fdc_pkg::CMD_FORCE_INT) begin
                v_ph = PH_IDLE;
            end else if (r_status[fdc_pkg::ST_BUSY]) begin
                v_done = 1'b1;
            end else begin
                n_status = fdc_pkg::ST_BUSY_ONLY;
                n_intrq  = 1'b0;
                n_drq    = 1'b0;
                case (r_command[7:4])
                    fdc_pkg::CMD_RESTORE: begin
                        n_track = 8'd0;
                        n_head  = 8'd0;
                        n_wait  = WAIT_LOAD;
                        n_paw   = PH_TYPE1;
                        v_ph    = PH_DELAY;
                    end
                    fdc_pkg::CMD_SEEK: begin
                        n_track = r_data;
                        n_head  = r_data;
                        n_wait  = WAIT_LOAD;
                        n_paw   = PH_TYPE1;
                        v_ph    = PH_DELAY;
                    end
                    fdc_pkg::CMD_STEP_IN, fdc_pkg::CMD_STEP_IN_U: begin
                        if (r_track < TRACK_LIMIT) begin
                            n_track = r_track + 8'd1;
                        end
                        n_head = n_track;
                        n_wait = WAIT_LOAD;
                        n_paw  = PH_TYPE1;
                        v_ph   = PH_DELAY;
                    end
                    fdc_pkg::CMD_STEP_OUT, fdc_pkg::CMD_STEP_OUT_U: begin
                        if (r_track != 8'd0) begin
                            n_track = r_track - 8'd1;
                        end
                        n_head = n_track;
                        n_wait = WAIT_LOAD;
                        n_paw  = PH_TYPE1;
                        v_ph   = PH_DELAY;
                    end
                    fdc_pkg::CMD_READ_SEC, fdc_pkg::CMD_READ_SEC_M: begin
                        n_base = w_new_base;
                        n_bc   = '0;
                        n_wait = WAIT_LOAD;
                        n_paw  = PH_READING;
                        v_ph   = PH_DELAY;
                    end
                    default: begin
                        v_ph = PH_IDLE;
                    end
                endcase
            end
        end

        // First delay
        if (!v_done && v_ph == PH_DELAY) begin
            if (n_wait != 8'd0) begin
                n_wait = n_wait - 8'd1;
                v_done = 1'b1;
            end else begin
                n_wait = fdc_pkg::WAIT_SPENT;
                v_ph   = n_paw;
            end
        end

        // Type I status: index pulse and track 0
        if (!v_done && v_ph == PH_TYPE1) begin
            if ((n_index & fdc_pkg::INDEX_MASK) != 8'd0) begin
                n_status[fdc_pkg::ST_DRQ] = 1'b1;
            end
            if (n_head == 8'd0) begin
                n_status[fdc_pkg::ST_TRACK0] = 1'b1;
            end
            v_ph = PH_IDLE;
        end

        // First read step
        if (!v_done && v_ph == PH_READING) begin
            if (n_bc >= SECTOR_LEN) begin
                v_ph = PH_IDLE;
            end else begin
                n_data  = i_item.disk_byte;
                v_fetch = 1'b1;
                n_bc    = n_bc + BC_W'(1);
                n_drq   = 1'b1;
                n_status[fdc_pkg::ST_DRQ] = 1'b1;
                n_wait  = WAIT_LOAD;
                n_paw   = PH_READING;
                v_ph    = PH_DELAY;
            end
        end

        // Second delay, only after a fetch
        if (!v_done && v_ph == PH_DELAY) begin
            if (n_wait != 8'd0) begin
                n_wait = n_wait - 8'd1;
                v_done = 1'b1;
            end else begin
                n_wait = fdc_pkg::WAIT_SPENT;
                v_ph   = n_paw;
            end
        end

        // Second read step: one fetch per pass, so hold in reading
        if (!v_done && v_ph == PH_READING) begin
            if (n_bc >= SECTOR_LEN) begin
                v_ph = PH_IDLE;
            end else if (v_fetch) begin
                v_done = 1'b1;
            end else begin
                v_ph = PH_IDLE;
            end
        end

        // Idle pass
        if (!v_done) begin
            v_ph = PH_IDLE;
            n_status[fdc_pkg::ST_BUSY] = 1'b0;
            n_drq   = 1'b0;
            n_intrq = 1'b1;
        end

        n_phase = v_ph;
        w_fetch = v_fetch;

        // Bus access
        if (i_item.req_type == fdc_pkg::REQ_WRITE) begin
            case (i_item.reg_addr)
                fdc_pkg::REG_CMD: begin
                    n_command = i_item.write_data;
                    n_phase   = PH_COMMAND;
                end
                fdc_pkg::REG_TRACK:  n_track  = i_item.write_data;
                fdc_pkg::REG_SECTOR: n_sector = i_item.write_data;
                default: begin
                    n_status[fdc_pkg::ST_DRQ] = 1'b0;
                    n_drq  = 1'b0;
                    n_data = i_item.write_data;
                end
            endcase
        end else begin
            case (i_item.reg_addr)
                fdc_pkg::REG_CMD: begin
                    n_intrq = 1'b0;
                    w_rdata = n_status;
                end
                fdc_pkg::REG_TRACK:  w_rdata = n_track;
                fdc_pkg::REG_SECTOR: w_rdata = n_sector;
                default: begin
                    n_status[fdc_pkg::ST_DRQ] = 1'b0;
                    n_drq   = 1'b0;
                    w_rdata = n_data;
                end
            endcase
        end
    end

    assign o_rsp.read_data   = w_rdata;
    assign o_rsp.drq_line    = n_drq;
    assign o_rsp.intrq_line  = n_intrq;
    assign o_rsp.disk_fetch  = w_fetch;
    assign o_rsp.disk_offset = n_base + 32'(n_bc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_paw     <= PH_IDLE;
            r_status  <= 8'd0;
            r_data    <= 8'd0;
            r_track   <= 8'd0;
            r_sector  <= 8'd0;
            r_command <= 8'd0;
            r_head    <= 8'd0;
            r_drq     <= 1'b0;
            r_intrq   <= 1'b0;
            r_wait    <= 8'd0;
            r_index   <= 8'd0;
            r_bc      <= '0;
            r_base    <= 32'd0;
        end else if (i_fire) begin
            r_phase   <= n_phase;
            r_paw     <= n_paw;
            r_status  <= n_status;
            r_data    <= n_data;
            r_track   <= n_track;
            r_sector  <= n_sector;
            r_command <= n_command;
            r_head    <= n_head;
            r_drq     <= n_drq;
            r_intrq   <= n_intrq;
            r_wait    <= n_wait;
            r_index   <= n_index;
            r_bc      <= n_bc;
            r_base    <= n_base;
        end
    end

`ifndef NO_ASSERTIONS
    a_bc_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bc <= SECTOR_LEN)
        else $error("byte count beyond sector length");

    a_delay_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DELAY) |-> (r_paw == PH_TYPE1 || r_paw == PH_READING))
        else $error("delay without a type I or read target");

    a_fetch_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && w_fetch) |->
            (r_phase == PH_DELAY || r_phase == PH_READING || r_phase == PH_COMMAND))
        else $error("image byte fetched from a phase that cannot read");

    a_index_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && i_fire) |=> (r_index == $past(r_index) + 8'd1))
        else $error("index counter did not advance by one");
`endif

endmodule

`default_nettype wire
